FILE: rtl/core/lti_pkg.sv
// Shared constants and helpers for the line/triangle intersection unit.
`timescale 1ns / 1ps
`default_nettype none

package lti_pkg;

  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned NUM_VERTS = 3;
  localparam int unsigned VERT_W    = 48;
  localparam int unsigned FLAG_W    = 2;
  localparam int unsigned FLAG_HIT  = 0;
  localparam int unsigned FLAG_DEGN = 1;

  function automatic int unsigned next3(input int unsigned i);
    return (i == 2) ? 0 : i + 1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/line_triangle_intersect_unit.sv
// Pipelined line/triangle intersection by signed volumes with a bit-per-stage divider.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: origin, direction, three vertices
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: point; tuser: hit, degenerate
//
//  One word enters per cycle unless a stalled output holds a full pipeline; there are
//  seven arithmetic stages, one divider stage per quotient bit and one output register.
//  The divider producing one quotient bit per stage sets the depth.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  Each stage holds while its successor is full and stalled; empty stages keep filling.
`timescale 1ns / 1ps
`default_nettype none

module line_triangle_intersect_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // org_x, org_y, org_z, dir_x, dir_y, dir_z, vert_zero, vert_one, vert_two
  input  wire logic [((6*COORD_BITS+3*lti_pkg::VERT_W+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // pt_x, pt_y, pt_z
  output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // hit, degenerate
  output logic [lti_pkg::FLAG_W-1:0] m_axis_tuser
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned OUT_W = ((3*C+7)/8)*8;
  localparam int unsigned VX_W  = (3*C > lti_pkg::VERT_W) ? 3*C : lti_pkg::VERT_W;
  localparam int unsigned E     = C + 1;
  localparam int unsigned PW    = 2*E;
  localparam int unsigned CW    = 2*E + 1;
  localparam int unsigned DW    = C + CW;
  localparam int unsigned VW    = DW + 2;
  localparam int unsigned SW    = VW + 2;
  localparam int unsigned MW    = VW + C;
  localparam int unsigned NW    = MW + 2;
  localparam int unsigned Q     = C;
  localparam int unsigned NST   = Q + 8;
  localparam int unsigned A     = lti_pkg::NUM_AXES;
  localparam int unsigned V     = lti_pkg::NUM_VERTS;

  typedef struct packed {
    logic                  hit;
    logic                  degn;
    logic [A-1:0]          neg;
    logic [SW-1:0]         den;
    logic [A-1:0][NW-1:0]  rem;
    logic [A-1:0][Q-1:0]   quo;
  } div_t;

  logic [NST-1:0] vld_q;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = m_axis_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  logic signed [C-1:0] org   [A];
  logic signed [C-1:0] dir   [A];
  logic signed [C-1:0] in_vc [V][A];
  logic [VX_W-1:0]     vx    [V];

  always_comb begin
    for (int k = 0; k < A; k++) begin
      org[k] = $signed(s_axis_tdata[k*C +: C]);
      dir[k] = $signed(s_axis_tdata[(A+k)*C +: C]);
    end
    for (int v = 0; v < V; v++) begin
      vx[v] = VX_W'(s_axis_tdata[6*C + v*lti_pkg::VERT_W +: lti_pkg::VERT_W]);
      for (int k = 0; k < A; k++) begin
        in_vc[v][k] = $signed(vx[v][k*C +: C]);
      end
    end
  end

  // stage 1: edges from origin
  logic signed [E-1:0] s1_e_q  [V][A];
  logic signed [C-1:0] s1_d_q  [A];
  logic signed [C-1:0] s1_vc_q [V][A];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int v = 0; v < V; v++) begin
        for (int k = 0; k < A; k++) begin
          s1_e_q[v][k]  <= $signed({in_vc[v][k][C-1], in_vc[v][k]})
                         - $signed({org[k][C-1], org[k]});
          s1_vc_q[v][k] <= in_vc[v][k];
        end
      end
      for (int k = 0; k < A; k++) begin
        s1_d_q[k] <= dir[k];
      end
    end
  end

  // stage 2: cross product terms
  logic signed [PW-1:0] s2_pr_q [V][A][2];
  logic signed [C-1:0]  s2_d_q  [A];
  logic signed [C-1:0]  s2_vc_q [V][A];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < V; i++) begin
        for (int k = 0; k < A; k++) begin
          s2_pr_q[i][k][0] <=
            PW'(s1_e_q[lti_pkg::next3(i)][lti_pkg::next3(k)])
            * PW'(s1_e_q[lti_pkg::next3(lti_pkg::next3(i))]
                        [lti_pkg::next3(lti_pkg::next3(k))]);
          s2_pr_q[i][k][1] <=
            PW'(s1_e_q[lti_pkg::next3(i)][lti_pkg::next3(lti_pkg::next3(k))])
            * PW'(s1_e_q[lti_pkg::next3(lti_pkg::next3(i))][lti_pkg::next3(k)]);
        end
      end
      s2_d_q  <= s1_d_q;
      s2_vc_q <= s1_vc_q;
    end
  end

  // stage 3: cross products
  logic signed [CW-1:0] s3_c_q  [V][A];
  logic signed [C-1:0]  s3_d_q  [A];
  logic signed [C-1:0]  s3_vc_q [V][A];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < V; i++) begin
        for (int k = 0; k < A; k++) begin
          s3_c_q[i][k] <= CW'(s2_pr_q[i][k][0]) - CW'(s2_pr_q[i][k][1]);
        end
      end
      s3_d_q  <= s2_d_q;
      s3_vc_q <= s2_vc_q;
    end
  end

  // stage 4: direction terms
  logic signed [DW-1:0] s4_dc_q [V][A];
  logic signed [C-1:0]  s4_vc_q [V][A];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < V; i++) begin
        for (int k = 0; k < A; k++) begin
          s4_dc_q[i][k] <= DW'(s3_d_q[k]) * DW'(s3_c_q[i][k]);
        end
      end
      s4_vc_q <= s3_vc_q;
    end
  end

  // stage 5: volumes
  logic signed [VW-1:0] s5_vol_q [V];
  logic signed [C-1:0]  s5_vc_q  [V][A];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int i = 0; i < V; i++) begin
        s5_vol_q[i] <= VW'(s4_dc_q[i][0]) + VW'(s4_dc_q[i][1]) + VW'(s4_dc_q[i][2]);
      end
      s5_vc_q <= s4_vc_q;
    end
  end

  // stage 6: sign test, volume total, weighted vertices
  logic                 s6_hit_q;
  logic                 s6_degn_q;
  logic signed [SW-1:0] s6_sum_q;
  logic signed [MW-1:0] s6_mv_q [A][V];
  logic                 any_neg;
  logic                 any_pos;
  logic                 all_zero;

  always_comb begin
    any_neg  = 1'b0;
    any_pos  = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < V; i++) begin
      if (s5_vol_q[i][VW-1]) begin
        any_neg = 1'b1;
      end
      if (s5_vol_q[i] != '0) begin
        all_zero = 1'b0;
        if (!s5_vol_q[i][VW-1]) begin
          any_pos = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_hit_q  <= !(any_neg && any_pos);
      s6_degn_q <= all_zero;
      s6_sum_q  <= SW'(s5_vol_q[0]) + SW'(s5_vol_q[1]) + SW'(s5_vol_q[2]);
      for (int k = 0; k < A; k++) begin
        for (int i = 0; i < V; i++) begin
          s6_mv_q[k][i] <= MW'(s5_vol_q[i]) * MW'(s5_vc_q[i][k]);
        end
      end
    end
  end

  // stage 7: numerators and magnitudes, then one quotient bit per stage
  div_t                 div_q [Q+1];
  logic signed [NW-1:0] num   [A];
  div_t                 div0_d;

  always_comb begin
    div0_d      = '0;
    div0_d.hit  = s6_hit_q;
    div0_d.degn = s6_degn_q;
    div0_d.den  = s6_sum_q[SW-1] ? SW'(-s6_sum_q) : SW'(s6_sum_q);
    for (int k = 0; k < A; k++) begin
      num[k]         = NW'(s6_mv_q[k][0]) + NW'(s6_mv_q[k][1]) + NW'(s6_mv_q[k][2]);
      div0_d.neg[k]  = num[k][NW-1] ^ s6_sum_q[SW-1];
      div0_d.rem[k]  = num[k][NW-1] ? NW'(-num[k]) : NW'(num[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      div_q[0] <= div0_d;
    end
  end

  for (genvar j = 1; j <= Q; j++) begin : g_div
    div_t          step_d;
    logic [NW-1:0] dsh;

    always_comb begin
      step_d = div_q[j-1];
      dsh    = NW'(div_q[j-1].den) << (Q - j);
      for (int k = 0; k < A; k++) begin
        if (div_q[j-1].rem[k] >= dsh) begin
          step_d.rem[k] = div_q[j-1].rem[k] - dsh;
          step_d.quo[k] = {div_q[j-1].quo[k][Q-2:0], 1'b1};
        end else begin
          step_d.quo[k] = {div_q[j-1].quo[k][Q-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[6+j]) begin
        div_q[j] <= step_d;
      end
    end
  end

  // output register
  logic [OUT_W-1:0]          out_data_d;
  logic [OUT_W-1:0]          out_data_q;
  logic [lti_pkg::FLAG_W-1:0] out_flag_q;

  always_comb begin
    out_data_d = '0;
    if (div_q[Q].hit && !div_q[Q].degn) begin
      for (int k = 0; k < A; k++) begin
        out_data_d[k*C +: C] = div_q[Q].neg[k] ? C'(-div_q[Q].quo[k]) : div_q[Q].quo[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      out_data_q                     <= out_data_d;
      out_flag_q[lti_pkg::FLAG_HIT]  <= div_q[Q].hit;
      out_flag_q[lti_pkg::FLAG_DEGN] <= div_q[Q].degn;
    end
  end

  assign m_axis_tvalid = vld_q[NST-1];
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_flag_q;

  a_degn_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[lti_pkg::FLAG_DEGN] |-> m_axis_tuser[lti_pkg::FLAG_HIT])
    else $error("degenerate word without hit");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[lti_pkg::FLAG_HIT] |-> m_axis_tdata == '0)
    else $error("miss word carries a nonzero point");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input held off without an output stall");

  a_in_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted word lost in first stage");

endmodule

`default_nettype wire
